>>> design/ntt_polynomial_multiplier_defines.svh
// Assertion macros shared by the polynomial multiplier RTL.
`ifndef NTT_POLYNOMIAL_MULTIPLIER_DEFINES_SVH
`define NTT_POLYNOMIAL_MULTIPLIER_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define NTT_PM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that, when seen, must be followed by another in the next cycle.
`define NTT_PM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ntt_pm_pkg.sv
// Constants, codes and helper functions of the polynomial multiplier.
package ntt_pm_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int TOT_W      = CNT_W + 1;
   localparam int LG_W       = $clog2(ADDR_W + 2);

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 30;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;

   localparam logic [VALUE_W-1:0] MOD = 30'd998244353;
   // Primitive 2^23-th root of unity (3^119) and its inverse.
   localparam logic [VALUE_W-1:0] ROOT_FWD = 30'd15311432;
   localparam logic [VALUE_W-1:0] ROOT_INV = 30'd469870224;
   localparam int ROOT_LOG = 23;
   localparam int SQ_W     = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

   // Reverse the low lg bits of idx.
   function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] idx,
                                                 input logic [LG_W-1:0] lg);
      logic [ADDR_W-1:0] r;
      for (int b = 0; b < ADDR_W; b++) r[b] = idx[ADDR_W-1-b];
      return r >> (ADDR_W[LG_W-1:0] - lg);
   endfunction

endpackage

>>> design/ntt_pm_if.sv
// Valid/ready channel interfaces for command words and result words.
interface ntt_pm_req_if;
   logic                             valid;
   logic                             ready;
   logic [ntt_pm_pkg::CMD_W-1:0]     cmd;
   logic [ntt_pm_pkg::VALUE_W-1:0]   value;
   logic [ntt_pm_pkg::INDEX_W-1:0]   index;
   modport source (output valid, cmd, value, index, input ready);
   modport sink   (input valid, cmd, value, index, output ready);
endinterface

interface ntt_pm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ntt_pm_pkg::VALUE_W-1:0]   coefficient;
   logic [ntt_pm_pkg::CNT_W-1:0]     product_length;
   logic [ntt_pm_pkg::STATUS_W-1:0]  status;
   modport source (output valid, coefficient, product_length, status, input ready);
   modport sink   (input valid, coefficient, product_length, status, output ready);
endinterface

>>> design/ntt_polynomial_multiplier.sv
// Top level of the NTT polynomial multiplier modulo 998244353.
//
// Command words arrive on req_chan; every word returns exactly one result word
// on rsp_chan. Append-A and append-B words store one coefficient each (values
// of 998244353 or more are reduced once); a read word waits in S_READ
// because the product RAM has a registered read. A multiply word
// picks n, the smallest power of two covering length_a + length_b, copies both
// operands zero-padded and bit-reversed into work RAMs, runs two forward NTTs,
// a pointwise product, an inverse NTT and a scaling pass by n^-1, then empties
// both operand stores. All modular products go through one bit-serial
// multiplier, so a multiply runs 3 * (n/2) * log2(n) butterflies through it, plus
// the copy, the pointwise and scaling passes and the squarings that derive each
// stage's twiddle root (23 - stage squarings per stage). The block is not ready
// during a multiply. A multiply whose n would exceed 1024 returns status 2 and
// only empties the operand stores. Reads at or beyond product_length return
// status 3.
`include "ntt_polynomial_multiplier_defines.svh"

module ntt_polynomial_multiplier (
   input  logic               clock,
   input  logic               reset,
   ntt_pm_req_if.sink         req_chan,
   ntt_pm_rsp_if.source       rsp_chan
);
   localparam int AW = ntt_pm_pkg::ADDR_W;
   localparam int CW = ntt_pm_pkg::CNT_W;
   localparam int VW = ntt_pm_pkg::VALUE_W;
   localparam int LW = ntt_pm_pkg::LG_W;
   localparam int TW = ntt_pm_pkg::TOT_W;
   localparam int QW = ntt_pm_pkg::SQ_W;

   // Sequencer states
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
   localparam logic [ST_W-1:0] S_READ     = 5'd1;
   localparam logic [ST_W-1:0] S_COPY_RD  = 5'd2;
   localparam logic [ST_W-1:0] S_COPY_WR  = 5'd3;
   localparam logic [ST_W-1:0] S_STAGE    = 5'd4;
   localparam logic [ST_W-1:0] S_ROOT_SQ  = 5'd5;
   localparam logic [ST_W-1:0] S_ROOT_CAP = 5'd6;
   localparam logic [ST_W-1:0] S_BF_RDU   = 5'd7;
   localparam logic [ST_W-1:0] S_BF_RDV   = 5'd8;
   localparam logic [ST_W-1:0] S_BF_MUL   = 5'd9;
   localparam logic [ST_W-1:0] S_BF_WRU   = 5'd10;
   localparam logic [ST_W-1:0] S_BF_WRV   = 5'd11;
   localparam logic [ST_W-1:0] S_BF_TW    = 5'd12;
   localparam logic [ST_W-1:0] S_PW_RD    = 5'd13;
   localparam logic [ST_W-1:0] S_PW_MUL   = 5'd14;
   localparam logic [ST_W-1:0] S_PW_WR    = 5'd15;
   localparam logic [ST_W-1:0] S_SC_RD    = 5'd16;
   localparam logic [ST_W-1:0] S_SC_MUL   = 5'd17;
   localparam logic [ST_W-1:0] S_SC_WR    = 5'd18;
   localparam logic [ST_W-1:0] S_MWAIT    = 5'd19;
   localparam logic [ST_W-1:0] S_FINISH   = 5'd20;

   // Which transform is running
   localparam logic [1:0] PH_FX  = 2'd0;
   localparam logic [1:0] PH_FY  = 2'd1;
   localparam logic [1:0] PH_INV = 2'd2;

   // ---------------- state ----------------
   logic [ST_W-1:0] state_ff, state_in, ret_ff, ret_in;
   logic [1:0]      phase_ff, phase_in;
   logic [CW-1:0]   len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [CW-1:0]   prod_cnt_ff, prod_cnt_in;
   logic [LW-1:0]   logn_ff, logn_in;
   logic [LW-1:0]   stage_ff, stage_in;
   logic [QW-1:0]   sq_ff, sq_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   blk_ff, blk_in;
   logic [AW-1:0]   k_ff, k_in;
   logic [VW-1:0]   wl_ff, wl_in;
   logic [VW-1:0]   w_ff, w_in;
   logic [VW-1:0]   u_ff, u_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                    rsp_coef_ff, rsp_coef_in;
   logic [ntt_pm_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // ---------------- shared modular multiplier ----------------
   logic            mm_start;
   logic [VW-1:0]   mm_a, mm_b;
   logic [VW+1:0]   mm_acc_ff, mm_acc_in;
   logic [VW-1:0]   mm_x_ff, mm_x_in, mm_y_ff, mm_y_in;
   logic [QW-1:0]   mm_cnt_ff, mm_cnt_in;
   logic            mm_busy_ff, mm_busy_in;
   logic            mm_done;
   logic [VW-1:0]   mm_res;
   logic [VW+2:0]   mm_sum;

   // ---------------- RAM ports ----------------
   logic            a_we, b_we, x_we, y_we, p_we;
   logic [AW-1:0]   a_waddr, b_waddr, w_addr, rd_addr, p_raddr;
   logic [VW-1:0]   in_value, x_wdata, y_wdata, seq_wdata;
   logic [VW-1:0]   a_rdata, b_rdata, x_rdata, y_rdata, p_rdata, sel_rdata;

   // ---------------- derived values ----------------
   logic            accept;
   logic [TW-1:0]   total;
   logic [LW-1:0]   lg_need;
   logic [CW-1:0]   n_pts, n_m1, half, step;
   logic [AW-1:0]   j_lo, j_hi, rev_idx;
   logic [VW:0]     bf_sum, bf_diff;
   logic [VW-1:0]   inv_n;
   logic            last_idx;

   assign accept   = req_chan.valid && req_chan.ready;
   assign in_value = (req_chan.value >= ntt_pm_pkg::MOD) ?
                     req_chan.value - ntt_pm_pkg::MOD : req_chan.value;
   assign total    = TW'(len_a_ff) + TW'(len_b_ff);

   // Smallest lg with 2^lg >= total
   always_comb begin
      lg_need = '0;
      for (int b = 0; b < AW; b++) begin
         if ((TW'(1) << b) < total) lg_need = LW'(b + 1);
      end
   end

   assign n_pts    = CW'(1) << logn_ff;
   assign n_m1     = n_pts - CW'(1);
   assign last_idx = (CW'(idx_ff) == n_m1);
   assign half     = CW'(1) << (stage_ff - LW'(1));
   assign step     = half << 1;
   assign j_lo     = blk_ff + k_ff;
   assign j_hi     = j_lo + half[AW-1:0];
   assign rev_idx  = ntt_pm_pkg::bit_rev(idx_ff, logn_ff);
   // n^-1 = MOD - (MOD-1)/n for a power of two n
   assign inv_n    = ntt_pm_pkg::MOD - ((ntt_pm_pkg::MOD - VW'(1)) >> logn_ff);

   assign bf_sum  = (VW+1)'(u_ff) + (VW+1)'(mm_res);
   assign bf_diff = (u_ff >= mm_res) ? (VW+1)'(u_ff - mm_res) :
                    (VW+1)'(u_ff) + (VW+1)'(ntt_pm_pkg::MOD) - (VW+1)'(mm_res);

   always_comb begin
      unique case (phase_ff)
         PH_FX:   sel_rdata = x_rdata;
         PH_FY:   sel_rdata = y_rdata;
         default: sel_rdata = p_rdata;
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      phase_in      = phase_ff;
      len_a_in      = len_a_ff;
      len_b_in      = len_b_ff;
      prod_cnt_in   = prod_cnt_ff;
      logn_in       = logn_ff;
      stage_in      = stage_ff;
      sq_in         = sq_ff;
      idx_in        = idx_ff;
      blk_in        = blk_ff;
      k_in          = k_ff;
      wl_in         = wl_ff;
      w_in          = w_ff;
      u_in          = u_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_coef_in   = rsp_coef_ff;
      rsp_status_in = rsp_status_ff;
      mm_start      = 1'b0;
      mm_a          = w_ff;
      mm_b          = wl_ff;
      a_we          = 1'b0;
      b_we          = 1'b0;
      x_we          = 1'b0;
      y_we          = 1'b0;
      p_we          = 1'b0;
      rd_addr       = idx_ff;
      w_addr        = idx_ff;
      seq_wdata     = mm_res;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_coef_in   = '0;
               rsp_status_in = ntt_pm_pkg::STATUS_OK;
               unique case (req_chan.cmd)
                  ntt_pm_pkg::CMD_APPEND_A: begin
                     rsp_valid_in = 1'b1;
                     if (len_a_ff >= CW'(ntt_pm_pkg::MAX_POINTS)) begin
                        rsp_status_in = ntt_pm_pkg::STATUS_FULL;
                     end else begin
                        a_we     = 1'b1;
                        len_a_in = len_a_ff + CW'(1);
                     end
                  end
                  ntt_pm_pkg::CMD_APPEND_B: begin
                     rsp_valid_in = 1'b1;
                     if (len_b_ff >= CW'(ntt_pm_pkg::MAX_POINTS)) begin
                        rsp_status_in = ntt_pm_pkg::STATUS_FULL;
                     end else begin
                        b_we     = 1'b1;
                        len_b_in = len_b_ff + CW'(1);
                     end
                  end
                  ntt_pm_pkg::CMD_MULTIPLY: begin
                     if (total > TW'(ntt_pm_pkg::MAX_POINTS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ntt_pm_pkg::STATUS_TOO_LARGE;
                        len_a_in      = '0;
                        len_b_in      = '0;
                     end else begin
                        logn_in  = lg_need;
                        idx_in   = '0;
                        state_in = S_COPY_RD;
                     end
                  end
                  ntt_pm_pkg::CMD_READ: begin
                     if (CW'(req_chan.index) >= prod_cnt_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ntt_pm_pkg::STATUS_BAD_INDEX;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_coef_in  = p_rdata;
            state_in     = S_IDLE;
         end
         S_COPY_RD: begin
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            // zero-pad past each operand's length, land in bit-reversed order
            x_we   = 1'b1;
            y_we   = 1'b1;
            w_addr = rev_idx;
            if (last_idx) begin
               phase_in = PH_FX;
               stage_in = LW'(1);
               state_in = S_STAGE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_COPY_RD;
            end
         end
         S_STAGE: begin
            if (stage_ff > logn_ff) begin
               stage_in = LW'(1);
               idx_in   = '0;
               unique case (phase_ff)
                  PH_FX:   phase_in = PH_FY;
                  PH_FY:   state_in = S_PW_RD;
                  default: state_in = S_SC_RD;
               endcase
            end else begin
               wl_in    = (phase_ff == PH_INV) ? ntt_pm_pkg::ROOT_INV : ntt_pm_pkg::ROOT_FWD;
               sq_in    = QW'(ntt_pm_pkg::ROOT_LOG) - QW'(stage_ff);
               blk_in   = '0;
               k_in     = '0;
               w_in     = VW'(1);
               state_in = S_ROOT_SQ;
            end
         end
         S_ROOT_SQ: begin
            // square the 2^23-th root down to the stage's root
            if (sq_ff == '0) begin
               state_in = S_BF_RDU;
            end else begin
               mm_start = 1'b1;
               mm_a     = wl_ff;
               mm_b     = wl_ff;
               sq_in    = sq_ff - QW'(1);
               ret_in   = S_ROOT_CAP;
               state_in = S_MWAIT;
            end
         end
         S_ROOT_CAP: begin
            wl_in    = mm_res;
            state_in = S_ROOT_SQ;
         end
         S_BF_RDU: begin
            rd_addr  = j_lo;
            state_in = S_BF_RDV;
         end
         S_BF_RDV: begin
            rd_addr  = j_hi;
            u_in     = sel_rdata;
            state_in = S_BF_MUL;
         end
         S_BF_MUL: begin
            mm_start = 1'b1;
            mm_a     = sel_rdata;
            mm_b     = w_ff;
            ret_in   = S_BF_WRU;
            state_in = S_MWAIT;
         end
         S_BF_WRU: begin
            w_addr    = j_lo;
            seq_wdata = (bf_sum >= (VW+1)'(ntt_pm_pkg::MOD)) ?
                        VW'(bf_sum - (VW+1)'(ntt_pm_pkg::MOD)) : VW'(bf_sum);
            x_we      = (phase_ff == PH_FX);
            y_we      = (phase_ff == PH_FY);
            p_we      = (phase_ff == PH_INV);
            state_in  = S_BF_WRV;
         end
         S_BF_WRV: begin
            w_addr    = j_hi;
            seq_wdata = VW'(bf_diff);
            x_we      = (phase_ff == PH_FX);
            y_we      = (phase_ff == PH_FY);
            p_we      = (phase_ff == PH_INV);
            if ((CW'(k_ff) + CW'(1)) < half) begin
               // advance the twiddle within the block
               k_in     = k_ff + AW'(1);
               mm_start = 1'b1;
               mm_a     = w_ff;
               mm_b     = wl_ff;
               ret_in   = S_BF_TW;
               state_in = S_MWAIT;
            end else begin
               k_in = '0;
               w_in = VW'(1);
               if ((CW'(blk_ff) + step) >= n_pts) begin
                  stage_in = stage_ff + LW'(1);
                  state_in = S_STAGE;
               end else begin
                  blk_in   = AW'(CW'(blk_ff) + step);
                  state_in = S_BF_RDU;
               end
            end
         end
         S_BF_TW: begin
            w_in     = mm_res;
            state_in = S_BF_RDU;
         end
         S_PW_RD: begin
            state_in = S_PW_MUL;
         end
         S_PW_MUL: begin
            mm_start = 1'b1;
            mm_a     = x_rdata;
            mm_b     = y_rdata;
            ret_in   = S_PW_WR;
            state_in = S_MWAIT;
         end
         S_PW_WR: begin
            // pointwise product goes to the product RAM bit-reversed for the inverse pass
            p_we   = 1'b1;
            w_addr = rev_idx;
            if (last_idx) begin
               phase_in = PH_INV;
               stage_in = LW'(1);
               state_in = S_STAGE;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_PW_RD;
            end
         end
         S_SC_RD: begin
            state_in = S_SC_MUL;
         end
         S_SC_MUL: begin
            mm_start = 1'b1;
            mm_a     = p_rdata;
            mm_b     = inv_n;
            ret_in   = S_SC_WR;
            state_in = S_MWAIT;
         end
         S_SC_WR: begin
            p_we = 1'b1;
            if (last_idx) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = S_SC_RD;
            end
         end
         S_MWAIT: begin
            if (mm_done) state_in = ret_ff;
         end
         S_FINISH: begin
            prod_cnt_in   = n_pts;
            len_a_in      = '0;
            len_b_in      = '0;
            rsp_valid_in  = 1'b1;
            rsp_coef_in   = '0;
            rsp_status_in = ntt_pm_pkg::STATUS_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------- bit-serial modular multiplier ----------------
   // acc = 2*acc + bit*x, then fold back below MOD; MSB of y first.
   assign mm_sum  = {mm_acc_ff, 1'b0} + (VW+3)'(mm_y_ff[VW-1] ? mm_x_ff : '0);
   assign mm_done = mm_busy_ff && (mm_cnt_ff == '0);
   assign mm_res  = mm_acc_ff[VW-1:0];

   always_comb begin
      mm_acc_in  = mm_acc_ff;
      mm_x_in    = mm_x_ff;
      mm_y_in    = mm_y_ff;
      mm_cnt_in  = mm_cnt_ff;
      mm_busy_in = mm_busy_ff;
      if (mm_start) begin
         mm_acc_in  = '0;
         mm_x_in    = mm_a;
         mm_y_in    = mm_b;
         mm_cnt_in  = QW'(VW - 1);
         mm_busy_in = 1'b1;
      end else if (mm_busy_ff) begin
         priority if (mm_sum >= (VW+3)'({ntt_pm_pkg::MOD, 1'b0})) begin
            mm_acc_in = (VW+2)'(mm_sum - (VW+3)'({ntt_pm_pkg::MOD, 1'b0}));
         end else if (mm_sum >= (VW+3)'(ntt_pm_pkg::MOD)) begin
            mm_acc_in = (VW+2)'(mm_sum - (VW+3)'(ntt_pm_pkg::MOD));
         end else begin
            mm_acc_in = (VW+2)'(mm_sum);
         end
         mm_y_in   = mm_y_ff << 1;
         mm_cnt_in = mm_cnt_ff - QW'(1);
         if (mm_cnt_ff == '0) mm_busy_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         prod_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         mm_busy_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         prod_cnt_ff  <= prod_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mm_busy_ff   <= mm_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      phase_ff      <= phase_in;
      logn_ff       <= logn_in;
      stage_ff      <= stage_in;
      sq_ff         <= sq_in;
      idx_ff        <= idx_in;
      blk_ff        <= blk_in;
      k_ff          <= k_in;
      wl_ff         <= wl_in;
      w_ff          <= w_in;
      u_ff          <= u_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_status_ff <= rsp_status_in;
      mm_acc_ff     <= mm_acc_in;
      mm_x_ff       <= mm_x_in;
      mm_y_ff       <= mm_y_in;
      mm_cnt_ff     <= mm_cnt_in;
   end

   // ---------------- memories ----------------
   assign a_waddr = len_a_ff[AW-1:0];
   assign b_waddr = len_b_ff[AW-1:0];
   assign x_wdata = (state_ff == S_COPY_WR) ?
                    ((CW'(idx_ff) < len_a_ff) ? a_rdata : '0) : seq_wdata;
   assign y_wdata = (state_ff == S_COPY_WR) ?
                    ((CW'(idx_ff) < len_b_ff) ? b_rdata : '0) : seq_wdata;
   assign p_raddr = (state_ff == S_IDLE) ? req_chan.index : rd_addr;

   ntt_pm_ram #(.WIDTH(VW), .DEPTH(ntt_pm_pkg::MAX_POINTS)) u_ram_a (
      .clock, .wr_en(a_we), .wr_addr(a_waddr), .wr_data(in_value),
      .rd_addr(rd_addr), .rd_data(a_rdata));

   ntt_pm_ram #(.WIDTH(VW), .DEPTH(ntt_pm_pkg::MAX_POINTS)) u_ram_b (
      .clock, .wr_en(b_we), .wr_addr(b_waddr), .wr_data(in_value),
      .rd_addr(rd_addr), .rd_data(b_rdata));

   ntt_pm_ram #(.WIDTH(VW), .DEPTH(ntt_pm_pkg::MAX_POINTS)) u_ram_x (
      .clock, .wr_en(x_we), .wr_addr(w_addr), .wr_data(x_wdata),
      .rd_addr(rd_addr), .rd_data(x_rdata));

   ntt_pm_ram #(.WIDTH(VW), .DEPTH(ntt_pm_pkg::MAX_POINTS)) u_ram_y (
      .clock, .wr_en(y_we), .wr_addr(w_addr), .wr_data(y_wdata),
      .rd_addr(rd_addr), .rd_data(y_rdata));

   ntt_pm_ram #(.WIDTH(VW), .DEPTH(ntt_pm_pkg::MAX_POINTS)) u_ram_p (
      .clock, .wr_en(p_we), .wr_addr(w_addr), .wr_data(seq_wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata));

   // ---------------- ports ----------------
   assign req_chan.ready          = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.coefficient    = rsp_coef_ff;
   assign rsp_chan.product_length = prod_cnt_ff;
   assign rsp_chan.status         = rsp_status_ff;

   // ---------------- assertions ----------------
   `NTT_PM_ASSERT(a_mm_no_restart, !(mm_start && mm_busy_ff), "multiplier restarted while busy")
   `NTT_PM_ASSERT_NEXT(a_mm_reduced, mm_done, mm_acc_ff < (VW+2)'(ntt_pm_pkg::MOD), "product not reduced")
   `NTT_PM_ASSERT_NEXT(a_finish_clears, state_ff == S_FINISH, (len_a_ff == '0) && (len_b_ff == '0) && rsp_valid_ff, "multiply end did not clear operands")
   `NTT_PM_ASSERT(a_busy_not_ready, !((state_ff != S_IDLE) && req_chan.ready), "ready while sequencer busy")
endmodule

>>> design/ntt_pm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ntt_pm_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> dv/ntt_pm_checker.sv
// Result checker for the NTT polynomial multiplier: predicts every result word and compares.
`timescale 1ns / 100ps

module ntt_pm_checker (
   input  logic         clock,
   input  logic         reset,
   ntt_pm_req_if.sink   req_mon,
   ntt_pm_rsp_if.sink   rsp_mon,
   output int           fail_count,
   output int           pending
);
   typedef struct packed {
      logic [ntt_pm_pkg::VALUE_W-1:0]  coefficient;
      logic [ntt_pm_pkg::CNT_W-1:0]    product_length;
      logic [ntt_pm_pkg::STATUS_W-1:0] status;
   } result_type;

   localparam longint P = 998244353;

   longint     a_coefs [ntt_pm_pkg::MAX_POINTS];
   longint     b_coefs [ntt_pm_pkg::MAX_POINTS];
   longint     product [ntt_pm_pkg::MAX_POINTS];
   int         len_a, len_b, prod_len;
   result_type expected_q[$];

   function automatic longint mod_pow(longint base, longint e);
      longint acc;
      acc = 1;
      base = base % P;
      while (e != 0) begin
         if (e[0]) acc = (acc * base) % P;
         base = (base * base) % P;
         e = e >> 1;
      end
      return acc;
   endfunction

   // In-place radix-2 transform; bit-reverses its natural-order input first, inverse also scales by n^-1.
   task automatic run_ntt(ref longint v [ntt_pm_pkg::MAX_POINTS], input int n, input bit inv);
      int     r, bt, half, blk, k;
      longint wl, w, u, t, tmp, scale;
      r = 0;
      for (int i = 1; i < n; i++) begin
         bt = n >> 1;
         while ((r & bt) != 0) begin
            r ^= bt;
            bt >>= 1;
         end
         r ^= bt;
         if (i < r) begin
            tmp = v[i]; v[i] = v[r]; v[r] = tmp;
         end
      end
      for (int step = 2; step <= n; step <<= 1) begin
         half = step >> 1;
         wl = mod_pow(3, (P - 1) / step);
         if (inv) wl = mod_pow(wl, P - 2);
         for (blk = 0; blk < n; blk += step) begin
            w = 1;
            for (k = 0; k < half; k++) begin
               u = v[blk+k];
               t = (v[blk+k+half] * w) % P;
               v[blk+k] = (u + t) % P;
               v[blk+k+half] = (u - t + P) % P;
               w = (w * wl) % P;
            end
         end
      end
      if (inv) begin
         scale = mod_pow(n, P - 2);
         for (int i = 0; i < n; i++) v[i] = (v[i] * scale) % P;
      end
   endtask

   task automatic predict_word(input logic [ntt_pm_pkg::CMD_W-1:0] cmd,
                               input logic [ntt_pm_pkg::VALUE_W-1:0] value,
                               input logic [ntt_pm_pkg::INDEX_W-1:0] index);
      longint     x [ntt_pm_pkg::MAX_POINTS];
      longint     y [ntt_pm_pkg::MAX_POINTS];
      longint     val;
      int         n;
      result_type res;
      res = '0;
      val = value;
      if (val >= P) val -= P;
      case (cmd)
         ntt_pm_pkg::CMD_APPEND_A: begin
            if (len_a >= ntt_pm_pkg::MAX_POINTS) res.status = ntt_pm_pkg::STATUS_FULL;
            else a_coefs[len_a++] = val;
         end
         ntt_pm_pkg::CMD_APPEND_B: begin
            if (len_b >= ntt_pm_pkg::MAX_POINTS) res.status = ntt_pm_pkg::STATUS_FULL;
            else b_coefs[len_b++] = val;
         end
         ntt_pm_pkg::CMD_MULTIPLY: begin
            n = 1;
            while (n < len_a + len_b && n <= ntt_pm_pkg::MAX_POINTS) n <<= 1;
            if (n > ntt_pm_pkg::MAX_POINTS) begin
               res.status = ntt_pm_pkg::STATUS_TOO_LARGE;
            end else begin
               for (int i = 0; i < ntt_pm_pkg::MAX_POINTS; i++) begin
                  x[i] = (i < len_a) ? a_coefs[i] : 0;
                  y[i] = (i < len_b) ? b_coefs[i] : 0;
               end
               run_ntt(x, n, 1'b0);
               run_ntt(y, n, 1'b0);
               for (int i = 0; i < n; i++) x[i] = (x[i] * y[i]) % P;
               run_ntt(x, n, 1'b1);
               for (int i = 0; i < n; i++) product[i] = x[i];
               prod_len = n;
            end
            len_a = 0;
            len_b = 0;
         end
         default: begin
            if (index >= prod_len) res.status = ntt_pm_pkg::STATUS_BAD_INDEX;
            else res.coefficient = ntt_pm_pkg::VALUE_W'(product[index]);
         end
      endcase
      res.product_length = ntt_pm_pkg::CNT_W'(prod_len);
      expected_q.push_back(res);
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         len_a = 0;
         len_b = 0;
         prod_len = 0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.coefficient, rsp_mon.product_length, rsp_mon.status};
            if (expected_q.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) $display("unexpected result word %h", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("result word: expected coef %0d len %0d st %0d, got %0d %0d %0d",
                              want.coefficient, want.product_length, want.status,
                              got.coefficient, got.product_length, got.status);
               end
            end
         end
         // predict after the compare, so a same-edge word is never matched against itself
         if (req_mon.valid && req_mon.ready)
            predict_word(req_mon.cmd, req_mon.value, req_mon.index);
      end
      pending = expected_q.size();
   end

endmodule

>>> dv/ntt_polynomial_multiplier_tb.sv
// Testbench top for the NTT polynomial multiplier: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module ntt_polynomial_multiplier_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   bit   idle_on = 1'b1;   // drop to end random idling in the last part of the run
   bit   hold_rsp = 1'b0;  // long receiver hold-off

   ntt_pm_req_if req_chan ();
   ntt_pm_rsp_if rsp_chan ();

   ntt_polynomial_multiplier dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   ntt_pm_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan.sink),
      .rsp_mon    (rsp_chan.sink),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   // Limit: stop the run and report a mismatch if it has not finished by then.
   initial begin
      #(8 * 64'd40_000_000);
      $display("ntt_polynomial_multiplier: mismatch");
      $finish;
   end

   // Receiver: random stall bursts, plus the long hold-off requested by the stimulus.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_chan.ready <= 1'b0;
            for (int i = 0; i < gap; i++) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one word and hold it until accepted; maybe idle first.
   task automatic send_word(input logic [ntt_pm_pkg::CMD_W-1:0] cmd,
                            input logic [ntt_pm_pkg::VALUE_W-1:0] value,
                            input logic [ntt_pm_pkg::INDEX_W-1:0] index);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_chan.valid <= 1'b0;
         for (int i = 0; i < gap; i++) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.value <= value;
      req_chan.index <= index;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   function automatic logic [ntt_pm_pkg::VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 30'd0;
         1: return 30'h3FFF_FFFF;
         2: return ntt_pm_pkg::MOD - 30'd1 + ntt_pm_pkg::VALUE_W'($urandom_range(0, 2));
         default: return ntt_pm_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // Load operands of the given lengths and multiply.
   task automatic multiply_random(input int la, input int lb);
      for (int i = 0; i < la; i++) send_word(ntt_pm_pkg::CMD_APPEND_A, rand_value(), '0);
      for (int i = 0; i < lb; i++) send_word(ntt_pm_pkg::CMD_APPEND_B, rand_value(), '0);
      send_word(ntt_pm_pkg::CMD_MULTIPLY, ntt_pm_pkg::VALUE_W'($urandom),
                ntt_pm_pkg::INDEX_W'($urandom));
   endtask

   initial begin
      int cnt, na, nb;
      bit held;
      req_chan.valid = 1'b0;
      req_chan.cmd   = ntt_pm_pkg::CMD_APPEND_A;
      req_chan.value = '0;
      req_chan.index = '0;
      held           = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: read before any multiply, empty multiply, value edges, small products.
      send_word(ntt_pm_pkg::CMD_READ, '0, '0);
      send_word(ntt_pm_pkg::CMD_READ, '0, 10'h3FF);
      send_word(ntt_pm_pkg::CMD_MULTIPLY, '0, '0);
      send_word(ntt_pm_pkg::CMD_READ, '0, '0);
      send_word(ntt_pm_pkg::CMD_READ, '0, 10'd1);
      send_word(ntt_pm_pkg::CMD_APPEND_A, ntt_pm_pkg::MOD, '0);
      send_word(ntt_pm_pkg::CMD_APPEND_A, 30'h3FFF_FFFF, '0);
      send_word(ntt_pm_pkg::CMD_APPEND_B, ntt_pm_pkg::MOD - 30'd1, '0);
      send_word(ntt_pm_pkg::CMD_APPEND_B, 30'd1, '0);
      send_word(ntt_pm_pkg::CMD_MULTIPLY, '0, '0);
      for (int i = 0; i < 5; i++)
         send_word(ntt_pm_pkg::CMD_READ, '0, ntt_pm_pkg::INDEX_W'(i));
      send_word(ntt_pm_pkg::CMD_APPEND_A, 30'd7, '0);
      send_word(ntt_pm_pkg::CMD_MULTIPLY, '0, '0);
      send_word(ntt_pm_pkg::CMD_READ, '0, '0);

      // Random: mostly small load/multiply/read sequences with stray noise words.
      cnt = 0;
      while (cnt < 450) begin
         if (cnt > 100 && !held) begin
            hold_rsp = 1'b1;
            held     = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_word(ntt_pm_pkg::CMD_READ, rand_value(), ntt_pm_pkg::INDEX_W'($urandom));
            cnt++;
         end else begin
            na = $urandom_range(0, 9);
            nb = $urandom_range(0, 9);
            multiply_random(na, nb);
            cnt += na + nb + 1;
            for (int i = 0; i < 12; i++) begin
               send_word(ntt_pm_pkg::CMD_READ, rand_value(),
                         ntt_pm_pkg::INDEX_W'($urandom_range(0, 17)));
               cnt++;
            end
         end
      end

      // Capacity: full operand store, then a too-large multiply.
      for (int i = 0; i < 1024; i++) send_word(ntt_pm_pkg::CMD_APPEND_A, rand_value(), '0);
      send_word(ntt_pm_pkg::CMD_APPEND_A, rand_value(), '0);
      send_word(ntt_pm_pkg::CMD_APPEND_B, rand_value(), '0);
      send_word(ntt_pm_pkg::CMD_MULTIPLY, '0, '0);
      for (int i = 0; i < 4; i++)
         send_word(ntt_pm_pkg::CMD_READ, '0, ntt_pm_pkg::INDEX_W'($urandom));

      // Tail without idling: 513 coefficients give the largest product, n = 1024.
      idle_on = 1'b0;
      multiply_random(400, 113);
      send_word(ntt_pm_pkg::CMD_READ, '0, 10'h3FF);
      send_word(ntt_pm_pkg::CMD_READ, '0, '0);
      for (int i = 0; i < 6; i++)
         send_word(ntt_pm_pkg::CMD_READ, '0, ntt_pm_pkg::INDEX_W'($urandom));
      req_chan.valid <= 1'b0;

      // Drain, then allow a short tail for stray words.
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("ntt_polynomial_multiplier: match");
      end else begin
         $display("ntt_polynomial_multiplier: mismatch");
      end
      $finish;
   end

endmodule
